// File: src/ftlb_pkg.sv
// Shared widths, defaults, state encoding and chain word type for the translation buffer.
`default_nettype none
package ftlb_pkg;

    localparam int PAGE_W          = 8;
    localparam int FRAME_W         = 8;
    localparam int OFFSET_IN_W     = 8;
    localparam int ADDR_W          = 16;
    localparam int SLOT_W          = 4;
    localparam int ENTRIES_DEF     = 16;
    localparam int OFFSET_BITS_DEF = 8;

    typedef enum logic {
        CMD_LOOKUP = 1'b0,
        CMD_INSERT = 1'b1
    } t_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

    typedef struct packed {
        logic               found;
        logic [FRAME_W-1:0] frame;
        logic [SLOT_W-1:0]  slot;
    } t_carry;

endpackage
`default_nettype wire

// File: src/ftlb_cell.sv
// One translation entry that checks the query page and passes the match word to its neighbor.
`default_nettype none
module ftlb_cell #(
    parameter int INDEX = 0
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_wr_en,
    input  wire logic [ftlb_pkg::PAGE_W-1:0]   i_wr_page,
    input  wire logic [ftlb_pkg::FRAME_W-1:0]  i_wr_frame,
    input  wire logic [ftlb_pkg::PAGE_W-1:0]   i_query_page,
    input  wire ftlb_pkg::t_carry              i_carry,
    output ftlb_pkg::t_carry                   o_carry
);

    logic                         r_valid;
    logic [ftlb_pkg::PAGE_W-1:0]  r_page;
    logic [ftlb_pkg::FRAME_W-1:0] r_frame;
    ftlb_pkg::t_carry             r_carry;
    ftlb_pkg::t_carry             n_carry;

    always_comb begin
        n_carry = i_carry;
        if (!i_carry.found && r_valid && (r_page == i_query_page)) begin
            n_carry.found = 1'b1;
            n_carry.frame = r_frame;
            n_carry.slot  = ftlb_pkg::SLOT_W'(INDEX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= 1'b0;
            r_carry.found <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid <= 1'b1;
            end
            r_carry.found <= n_carry.found;
        end
        if (i_wr_en) begin
            r_page  <= i_wr_page;
            r_frame <= i_wr_frame;
        end
        r_carry.frame <= n_carry.frame;
        r_carry.slot  <= n_carry.slot;
    end

    assign o_carry = r_carry;

endmodule
`default_nettype wire

// File: src/fifo_tlb_translate.sv
// Top level of the fully associative translation buffer with first-in first-out replacement.
//
// Input channel: i_valid / o_ready carry one word of i_command, i_page, i_frame_in
// and i_offset. Output channel: o_valid / i_ready carry one result word of o_hit,
// o_frame_out, o_physical_address and o_slot for every input word.
// An insert writes the entry at the replacement pointer in the accepting cycle and
// its result word is visible on the next cycle.
// A lookup sends a match word down the row of ENTRIES cells, one cell per cycle,
// and the first valid cell with the same page claims it. The result is captured
// from the last cell once the match word has passed through the whole row.
// One word is in flight at a time; a new word is accepted while the previous
// result waits only if the receiver takes that result in the same cycle.
// When the receiver stalls, the result register holds its word and a finished
// lookup waits at the end of the row until the register is free.
// Reset clears all valid marks, the replacement pointer and the output valid.
`default_nettype none
module fifo_tlb_translate #(
    parameter int ENTRIES     = ftlb_pkg::ENTRIES_DEF,
    parameter int OFFSET_BITS = ftlb_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic                              i_command,
    input  wire logic [ftlb_pkg::PAGE_W-1:0]       i_page,
    input  wire logic [ftlb_pkg::FRAME_W-1:0]      i_frame_in,
    input  wire logic [ftlb_pkg::OFFSET_IN_W-1:0]  i_offset,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic                                   o_hit,
    output logic [ftlb_pkg::FRAME_W-1:0]           o_frame_out,
    output logic [ftlb_pkg::ADDR_W-1:0]            o_physical_address,
    output logic [ftlb_pkg::SLOT_W-1:0]            o_slot
);

    localparam int PTR_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int WIDE_W = ftlb_pkg::FRAME_W + OFFSET_BITS + ftlb_pkg::OFFSET_IN_W;

    ftlb_pkg::t_state r_state;
    ftlb_pkg::t_state n_state;

    logic [PTR_W-1:0]                   r_ptr;
    logic [CNT_W-1:0]                   r_cnt;
    logic [ftlb_pkg::PAGE_W-1:0]        r_query_page;
    logic [ftlb_pkg::OFFSET_IN_W-1:0]   r_query_offset;

    logic                               r_out_valid;
    logic                               r_hit;
    logic [ftlb_pkg::FRAME_W-1:0]       r_frame_out;
    logic [ftlb_pkg::ADDR_W-1:0]        r_phys;
    logic [ftlb_pkg::SLOT_W-1:0]        r_slot;

    logic                               w_in_ready;
    logic                               w_accept;
    logic                               w_insert;
    logic                               w_done;
    logic                               w_out_free;
    logic [WIDE_W-1:0]                  w_wide_addr;
    logic [WIDE_W-1:0]                  w_off_mask;

    ftlb_pkg::t_carry                   w_carry [ENTRIES+1];

    assign w_out_free = !r_out_valid || i_ready;
    assign w_accept   = i_valid && w_in_ready;
    assign w_insert   = w_accept && (i_command == ftlb_pkg::CMD_INSERT);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ftlb_pkg::ST_IDLE: begin
                if (w_accept && (i_command == ftlb_pkg::CMD_LOOKUP)) begin
                    n_state = ftlb_pkg::ST_WALK;
                end
            end
            ftlb_pkg::ST_WALK: begin
                if (w_done) begin
                    n_state = ftlb_pkg::ST_IDLE;
                end
            end
            default: n_state = ftlb_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        w_in_ready = 1'b0;
        w_done     = 1'b0;
        unique case (r_state)
            ftlb_pkg::ST_IDLE: w_in_ready = w_out_free;
            ftlb_pkg::ST_WALK: w_done = (r_cnt == CNT_W'(ENTRIES)) && w_out_free;
            default: begin
                w_in_ready = 1'b0;
                w_done     = 1'b0;
            end
        endcase
    end

    assign w_carry[0] = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        ftlb_cell #(
            .INDEX(g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_wr_en     (w_insert && (r_ptr == PTR_W'(g))),
            .i_wr_page   (i_page),
            .i_wr_frame  (i_frame_in),
            .i_query_page(r_query_page),
            .i_carry     (w_carry[g]),
            .o_carry     (w_carry[g+1])
        );
    end

    assign w_off_mask  = (WIDE_W'(1) << OFFSET_BITS) - WIDE_W'(1);
    assign w_wide_addr = (WIDE_W'(w_carry[ENTRIES].frame) << OFFSET_BITS)
                       | (WIDE_W'(r_query_offset) & w_off_mask);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ftlb_pkg::ST_IDLE;
            r_ptr       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_insert) begin
                r_ptr <= (r_ptr == PTR_W'(ENTRIES - 1)) ? '0 : r_ptr + PTR_W'(1);
            end
            if (w_accept) begin
                r_cnt <= '0;
            end else if ((r_state == ftlb_pkg::ST_WALK) && (r_cnt != CNT_W'(ENTRIES))) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (w_insert || w_done) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_query_page   <= i_page;
            r_query_offset <= i_offset;
        end
        if (w_insert) begin
            r_hit       <= 1'b0;
            r_frame_out <= '0;
            r_phys      <= '0;
            r_slot      <= ftlb_pkg::SLOT_W'(r_ptr);
        end else if (w_done) begin
            r_hit <= w_carry[ENTRIES].found;
            if (w_carry[ENTRIES].found) begin
                r_frame_out <= w_carry[ENTRIES].frame;
                r_phys      <= w_wide_addr[ftlb_pkg::ADDR_W-1:0];
                r_slot      <= w_carry[ENTRIES].slot;
            end else begin
                r_frame_out <= '0;
                r_phys      <= '0;
                r_slot      <= '0;
            end
        end
    end

    assign o_ready            = w_in_ready;
    assign o_valid            = r_out_valid;
    assign o_hit              = r_hit;
    assign o_frame_out        = r_frame_out;
    assign o_physical_address = r_phys;
    assign o_slot             = r_slot;

endmodule
`default_nettype wire

// File: bench/fifo_tlb_translate_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the fifo_tlb_translate translation buffer.
module fifo_tlb_translate_tb;
    import ftlb_pkg::*;

    localparam int NUM_ENTRIES  = ENTRIES_DEF;
    localparam int OFF_BITS     = OFFSET_BITS_DEF;
    localparam int RANDOM_WORDS = 1150;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 2 * NUM_ENTRIES + 8;
    localparam logic [OFFSET_IN_W-1:0] OFFSET_MASK = OFFSET_IN_W'((1 << OFF_BITS) - 1);

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
        logic [ADDR_W-1:0]  addr;
        logic [SLOT_W-1:0]  slot;
    } xlat_word_t;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_valid    = 1'b0;
    logic                   o_ready;
    logic                   i_command  = 1'b0;
    logic [PAGE_W-1:0]      i_page     = '0;
    logic [FRAME_W-1:0]     i_frame_in = '0;
    logic [OFFSET_IN_W-1:0] i_offset   = '0;
    logic                   o_valid;
    logic                   i_ready    = 1'b0;
    logic                   o_hit;
    logic [FRAME_W-1:0]     o_frame_out;
    logic [ADDR_W-1:0]      o_physical_address;
    logic [SLOT_W-1:0]      o_slot;

    logic [PAGE_W-1:0]  tlb_page  [NUM_ENTRIES];
    logic [FRAME_W-1:0] tlb_frame [NUM_ENTRIES];
    logic               tlb_valid [NUM_ENTRIES];
    int unsigned        tlb_ptr = 0;

    xlat_word_t  expected_xlat[$];
    xlat_word_t  want;
    int unsigned mismatches    = 0;
    int unsigned cycle_count   = 0;
    int unsigned burst_left    = 0;
    bit          sender_idles  = 1'b0;
    int unsigned ready_mode    = 0;
    int unsigned stall_left    = 0;

    fifo_tlb_translate u_dut (.*);

    always #2 i_clk = ~i_clk;

    function automatic xlat_word_t translate(input t_cmd cmd, input logic [PAGE_W-1:0] page,
                                             input logic [FRAME_W-1:0] frame,
                                             input logic [OFFSET_IN_W-1:0] offset);
        xlat_word_t res;
        int         idx;
        res = '0;
        if (cmd == CMD_INSERT) begin
            tlb_page[tlb_ptr]  = page;
            tlb_frame[tlb_ptr] = frame;
            tlb_valid[tlb_ptr] = 1'b1;
            res.slot = SLOT_W'(tlb_ptr);
            tlb_ptr = (tlb_ptr + 1) % NUM_ENTRIES;
        end else begin
            // Scan downward so that the lowest matching index is the one kept.
            for (idx = NUM_ENTRIES - 1; idx >= 0; idx--) begin
                if (tlb_valid[idx] && tlb_page[idx] == page) begin
                    res.hit   = 1'b1;
                    res.frame = tlb_frame[idx];
                    res.addr  = (ADDR_W'(tlb_frame[idx]) << OFF_BITS)
                              | ADDR_W'(offset & OFFSET_MASK);
                    res.slot  = SLOT_W'(idx);
                end
            end
        end
        return res;
    endfunction

    task automatic send_word(input t_cmd cmd, input logic [PAGE_W-1:0] page,
                             input logic [FRAME_W-1:0] frame,
                             input logic [OFFSET_IN_W-1:0] offset);
        int unsigned gap;
        if (sender_idles && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        i_valid    <= 1'b1;
        i_command  <= cmd;
        i_page     <= page;
        i_frame_in <= frame;
        i_offset   <= offset;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_xlat.push_back(translate(cmd, page, frame, offset));
    endtask

    task automatic test_empty_lookups;
        send_word(CMD_LOOKUP, 8'h00, 8'h00, 8'h00);
        send_word(CMD_LOOKUP, 8'hFF, 8'hFF, 8'hFF);
        send_word(CMD_LOOKUP, 8'h5A, 8'hA5, 8'h3C);
    endtask

    task automatic test_insert_then_hit;
        send_word(CMD_INSERT, 8'h00, 8'hFF, 8'h00);
        send_word(CMD_INSERT, 8'hFF, 8'h00, 8'hFF);
        send_word(CMD_LOOKUP, 8'h00, 8'h00, 8'hFF);
        send_word(CMD_LOOKUP, 8'hFF, 8'hFF, 8'h00);
        send_word(CMD_INSERT, 8'h12, 8'hA5, 8'h00);
        send_word(CMD_LOOKUP, 8'h12, 8'h00, 8'h3C);
    endtask

    task automatic test_duplicate_pages;
        send_word(CMD_INSERT, 8'h00, 8'h33, 8'h00);
        send_word(CMD_LOOKUP, 8'h00, 8'h00, 8'h81);
    endtask

    task automatic test_replacement_wrap;
        int k;
        for (k = 0; k < NUM_ENTRIES - 4; k++) begin
            send_word(CMD_INSERT, 8'(8'h80 + k), 8'(8'h40 + k), 8'(k));
        end
        // The pointer has wrapped, so this insert replaces the first entry.
        send_word(CMD_INSERT, 8'h77, 8'hC3, 8'h00);
        send_word(CMD_LOOKUP, 8'h00, 8'h00, 8'h7E);
        send_word(CMD_LOOKUP, 8'h77, 8'h00, 8'hFF);
    endtask

    task automatic test_random_traffic;
        int          n;
        int unsigned pick;
        t_cmd        cmd;
        logic [7:0]  page;
        for (n = 0; n < RANDOM_WORDS; n++) begin
            sender_idles = (n >= 150) && !(n >= 600 && n < 700);
            cmd  = ($urandom_range(0, 99) < 40) ? CMD_INSERT : CMD_LOOKUP;
            pick = $urandom_range(0, 99);
            if (cmd == CMD_LOOKUP && pick < 60) begin
                page = tlb_page[$urandom_range(0, NUM_ENTRIES - 1)];
            end else if (pick < 70) begin
                page = 8'($urandom_range(0, 3));
            end else if (pick < 80) begin
                page = 8'($urandom_range(252, 255));
            end else begin
                page = 8'($urandom_range(0, 255));
            end
            send_word(cmd, page, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("fifo_tlb_translate_tb failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_xlat.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected word: hit=%0d frame=%02h addr=%04h slot=%0d",
                             o_hit, o_frame_out, o_physical_address, o_slot);
                end
            end else begin
                want = expected_xlat.pop_front();
                if (o_hit !== want.hit || o_frame_out !== want.frame
                        || o_physical_address !== want.addr || o_slot !== want.slot) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected hit=%0d frame=%02h addr=%04h slot=%0d, %s",
                                 want.hit, want.frame, want.addr, want.slot, "got below");
                        $display("          actual   hit=%0d frame=%02h addr=%04h slot=%0d",
                                 o_hit, o_frame_out, o_physical_address, o_slot);
                    end
                end
            end
        end
        if (cycle_count % 300 == 0) begin
            ready_mode = $urandom_range(0, 2);
        end
        case (ready_mode)
            0: begin
                i_ready <= 1'b1;
            end
            1: begin
                i_ready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                if (stall_left > 0) begin
                    stall_left--;
                    i_ready <= 1'b0;
                end else if ($urandom_range(0, 7) == 0) begin
                    stall_left = $urandom_range(1, 20);
                    i_ready <= 1'b0;
                end else begin
                    i_ready <= 1'b1;
                end
            end
        endcase
    end

    initial begin
        for (int e = 0; e < NUM_ENTRIES; e++) begin
            tlb_page[e]  = '0;
            tlb_frame[e] = '0;
            tlb_valid[e] = 1'b0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_lookups();
        test_insert_then_hit();
        test_duplicate_pages();
        test_replacement_wrap();
        test_random_traffic();
        i_valid <= 1'b0;
        while (expected_xlat.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_xlat.size() == 0) begin
            $display("fifo_tlb_translate_tb passed");
        end else begin
            $display("fifo_tlb_translate_tb failed");
        end
        $finish;
    end

endmodule

// File: files.f
src/ftlb_pkg.sv
src/ftlb_cell.sv
src/fifo_tlb_translate.sv
bench/fifo_tlb_translate_tb.sv
